// ===== rtl/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assertion macros
// small wrappers around concurrent assertions with a clock and an active-low
// asynchronous reset
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/bta_pkg.sv =====
// ---------------------------------------------------------------------------
// bta_pkg
// shared types, constants and helper functions of the number formatter
// ---------------------------------------------------------------------------
package bta_pkg;

	localparam int VALUE_W    = 32;
	localparam int CHAR_W     = 7;
	localparam int DIGIT_W    = 4;
	localparam int CNT_W      = 4;
	localparam int NUM_DIGITS = 10;
	localparam int MAX_CHARS  = 11;
	localparam int MULT_W     = 34;

	typedef enum logic [1:0] {
		ACT_UDEC = 2'd0,
		ACT_SDEC = 2'd1,
		ACT_HEX8 = 2'd2,
		ACT_HEX4 = 2'd3
	} action_t;

	localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
	localparam logic [CHAR_W-1:0] CH_A     = 7'h41;
	localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;

	typedef logic [MULT_W-1:0] mult_row_t [NUM_DIGITS];

	// item as it travels down the digit pipeline
	typedef struct packed {
		action_t                               action;
		logic                                  neg;
		logic [VALUE_W-1:0]                    rem;
		logic [NUM_DIGITS-1:0][DIGIT_W-1:0]    digits;
	} pipe_t;

	// formatted characters, first character in slot 0
	typedef struct packed {
		logic [MAX_CHARS-1:0][CHAR_W-1:0] chars;
		logic [CNT_W-1:0]                 count;
	} fmt_t;

	// power of ten for digit position idx (0 is the 1e9 position)
	function automatic logic [MULT_W-1:0] pow10(int idx);
		logic [MULT_W-1:0] p;
		p = MULT_W'(1);
		for (int i = 0; i < NUM_DIGITS - 1; i++) begin
			if (i < NUM_DIGITS - 1 - idx) begin
				p = MULT_W'(p * MULT_W'(10));
			end
		end
		return p;
	endfunction

	// multiples 0..9 of the power of ten for position idx
	function automatic mult_row_t mult_row(int idx);
		mult_row_t row;
		row[0] = '0;
		for (int d = 1; d < NUM_DIGITS; d++) begin
			row[d] = MULT_W'(row[d-1] + pow10(idx));
		end
		return row;
	endfunction

	function automatic logic [CHAR_W-1:0] hex_char(logic [DIGIT_W-1:0] nib);
		logic [CHAR_W-1:0] c;
		if (nib < DIGIT_W'(10)) begin
			c = CH_ZERO + {3'b000, nib};
		end else begin
			c = CH_A + {3'b000, nib} - 7'd10;
		end
		return c;
	endfunction

endpackage

// ===== rtl/bta_digit_stage.sv =====
// ---------------------------------------------------------------------------
// bta_digit_stage
// one decimal digit per stage for the decimal actions: compare against the
// nine multiples of the position's power of ten, subtract the largest that fits
// ---------------------------------------------------------------------------
module bta_digit_stage #(
	parameter int IDX = 0
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  bta_pkg::pipe_t in_pipe,
	output logic           out_valid,
	output bta_pkg::pipe_t out_pipe
);
	import bta_pkg::*;

	localparam mult_row_t MULT = mult_row(IDX);

	logic [DIGIT_W-1:0] digit;
	logic [MULT_W-1:0]  sub;
	pipe_t              nxt;
	// stage registers
	logic               valid_sn;
	pipe_t              pipe_sn;

	always_comb begin
		digit = '0;
		sub   = '0;
		// ascending scan, the largest multiple that fits wins
		for (int d = 1; d < NUM_DIGITS; d++) begin
			if ({2'b00, in_pipe.rem} >= MULT[d]) begin
				digit = DIGIT_W'(d);
				sub   = MULT[d];
			end
		end
		nxt = in_pipe;
		if (in_pipe.action == ACT_UDEC || in_pipe.action == ACT_SDEC) begin
			nxt.rem         = in_pipe.rem - sub[VALUE_W-1:0];
			nxt.digits[IDX] = digit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_sn <= 1'b0;
		end else if (en) begin
			valid_sn <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pipe_sn <= nxt;
		end
	end

	assign out_valid = valid_sn;
	assign out_pipe  = pipe_sn;

endmodule

// ===== rtl/bta_format_stage.sv =====
// ---------------------------------------------------------------------------
// bta_format_stage
// builds the character string: leading zero removal, sign, hex nibbles
// ---------------------------------------------------------------------------
module bta_format_stage (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic           in_valid,
	input  bta_pkg::pipe_t in_pipe,
	output logic           out_valid,
	output bta_pkg::fmt_t  out_fmt
);
	import bta_pkg::*;

	logic [DIGIT_W-1:0] lz;
	logic [DIGIT_W:0]   k;
	fmt_t               nxt;
	logic               valid_s12;
	fmt_t               fmt_s12;

	always_comb begin
		// first nonzero digit, the ones digit always prints
		lz = DIGIT_W'(NUM_DIGITS - 1);
		for (int i = NUM_DIGITS - 2; i >= 0; i--) begin
			if (in_pipe.digits[i] != '0) begin
				lz = DIGIT_W'(i);
			end
		end
		k   = '0;
		nxt = '0;
		unique case (in_pipe.action)
			ACT_UDEC, ACT_SDEC: begin
				for (int j = 0; j < MAX_CHARS; j++) begin
					k = (DIGIT_W+1)'(j) + {1'b0, lz} - {{DIGIT_W{1'b0}}, in_pipe.neg};
					if (in_pipe.neg && j == 0) begin
						nxt.chars[j] = CH_MINUS;
					end else if (k <= (DIGIT_W+1)'(NUM_DIGITS - 1)) begin
						nxt.chars[j] = CH_ZERO + {3'b000, in_pipe.digits[k[DIGIT_W-1:0]]};
					end else begin
						nxt.chars[j] = CH_ZERO;
					end
				end
				nxt.count = CNT_W'(NUM_DIGITS) - lz + {{(CNT_W-1){1'b0}}, in_pipe.neg};
			end
			ACT_HEX8: begin
				for (int j = 0; j < 8; j++) begin
					nxt.chars[j] = hex_char(in_pipe.rem[4*(7-j) +: 4]);
				end
				nxt.count = CNT_W'(8);
			end
			ACT_HEX4: begin
				for (int j = 0; j < 4; j++) begin
					nxt.chars[j] = hex_char(in_pipe.rem[4*(3-j) +: 4]);
				end
				nxt.count = CNT_W'(4);
			end
			default: begin
				nxt = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s12 <= 1'b0;
		end else if (en) begin
			valid_s12 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fmt_s12 <= nxt;
		end
	end

	assign out_valid = valid_s12;
	assign out_fmt   = fmt_s12;

endmodule

// ===== rtl/bta_emitter.sv =====
// ---------------------------------------------------------------------------
// bta_emitter
// shifts the formatted string out one character per cycle
// ---------------------------------------------------------------------------
module bta_emitter (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	input  bta_pkg::fmt_t                in_fmt,
	output logic                         ready,
	output logic                         strobe,
	output logic [bta_pkg::CHAR_W-1:0]   ascii_char,
	output logic                         last_char
);
	import bta_pkg::*;

	logic                              active_q;
	logic [CNT_W-1:0]                  cnt_q;
	logic [MAX_CHARS-1:0][CHAR_W-1:0]  chars_q;
	logic                              take;
	logic                              on_last;

	assign on_last = (cnt_q == CNT_W'(1));
	// free, or handing out the final character of the current string
	assign ready   = !active_q || on_last;
	assign take    = in_valid && ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			cnt_q    <= '0;
		end else if (take) begin
			active_q <= 1'b1;
			cnt_q    <= in_fmt.count;
		end else if (active_q) begin
			active_q <= !on_last;
			cnt_q    <= cnt_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			chars_q <= in_fmt.chars;
		end else if (active_q) begin
			chars_q <= chars_q >> CHAR_W;
		end
	end

	assign strobe     = active_q;
	assign ascii_char = chars_q[0];
	assign last_char  = active_q && on_last;

endmodule

// ===== rtl/binary_to_ascii_number_formatter_unit.sv =====
// ---------------------------------------------------------------------------
// binary_to_ascii_number_formatter_unit
// formats a 32-bit value as unsigned decimal, signed decimal, 8-digit hex or
// 4-digit hex and sends it out as ascii characters, one per cycle
// ---------------------------------------------------------------------------
//
//  channel   signals                    transfer when
//  --------  -------------------------  -----------------------------
//  command   start, busy, action, value start high and busy low
//  result    strobe, ascii_char,        every cycle strobe is high
//            last_char
//
//  path: the accepting edge loads the input stage; an accepted command goes
//  on through the ten digit stages, the format stage and the output register
//  before its first character is on the result ports
//  rate: one character per cycle, set by the single-character result port;
//  a number has 1 to 11 characters
//  busy rises while a finished string waits for the output shifter; every
//  stage before the shifter then holds, nothing is dropped or repeated
//  reset: arst_n clears all valid bits and the output shifter's active flag and count at once
//  the receiver cannot stall: strobe marks a character for one cycle only
//
module binary_to_ascii_number_formatter_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [1:0]                   action,
	input  logic [bta_pkg::VALUE_W-1:0]  value,
	output logic                         strobe,
	output logic [bta_pkg::CHAR_W-1:0]   ascii_char,
	output logic                         last_char
);
	import bta_pkg::*;

	`include "assert_macros.svh"

	// global pipeline enable, low while the format stage waits on the shifter
	logic   en;
	logic   valid_s1;
	pipe_t  pipe_s1;
	pipe_t  nxt_s1;

	// stage outputs of the digit chain, slot 0 is the input stage
	logic   stg_valid [NUM_DIGITS+1];
	pipe_t  stg_pipe  [NUM_DIGITS+1];

	logic   fmt_valid;
	fmt_t   fmt;
	logic   emit_ready;

	assign busy = fmt_valid && !emit_ready;
	assign en   = !busy;

	// input stage: sign handling, magnitude taken modulo 2^32 so the most
	// negative value needs no special case
	always_comb begin
		nxt_s1        = '0;
		nxt_s1.action = action_t'(action);
		nxt_s1.rem    = value;
		if (action_t'(action) == ACT_SDEC && value[VALUE_W-1]) begin
			nxt_s1.neg = 1'b1;
			nxt_s1.rem = VALUE_W'(0) - value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pipe_s1 <= nxt_s1;
		end
	end

	assign stg_valid[0] = valid_s1;
	assign stg_pipe[0]  = pipe_s1;

	// ten digit stages, most significant digit first
	for (genvar g = 0; g < NUM_DIGITS; g++) begin : g_digit
		bta_digit_stage #(
			.IDX (g)
		) u_digit (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (stg_valid[g]),
			.in_pipe   (stg_pipe[g]),
			.out_valid (stg_valid[g+1]),
			.out_pipe  (stg_pipe[g+1])
		);
	end

	bta_format_stage u_format (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (stg_valid[NUM_DIGITS]),
		.in_pipe   (stg_pipe[NUM_DIGITS]),
		.out_valid (fmt_valid),
		.out_fmt   (fmt)
	);

	bta_emitter u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (fmt_valid),
		.in_fmt     (fmt),
		.ready      (emit_ready),
		.strobe     (strobe),
		.ascii_char (ascii_char),
		.last_char  (last_char)
	);

	// a stall only happens while a string is mid-way out
	`ASSERT_IMPL(a_busy_while_emitting, clk, arst_n, busy, strobe && !last_char)
	// characters of one number leave back to back
	`ASSERT_NEXT(a_string_contiguous, clk, arst_n, strobe && !last_char, strobe)
	// the sign never ends a number
	`ASSERT_IMPL(a_minus_not_last, clk, arst_n, strobe && ascii_char == CH_MINUS, !last_char)

endmodule
